FILE: rtl/cbead_pkg.sv
// Shared types, constants and helpers for the button edge and axis deadzone unit.
`timescale 1ns / 1ps

package cbead_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int NUM_AXES    = 8;
  localparam int BTN_IW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int AXS_IW      = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [14:0] DEADZONE_RESET = 15'd6554;

  localparam logic [1:0] MODE_BUTTON = 2'd0;
  localparam logic [1:0] MODE_AXIS   = 2'd1;
  localparam logic [1:0] MODE_LINK   = 2'd2;

  localparam logic [1:0] ST_RELEASED      = 2'd0;
  localparam logic [1:0] ST_JUST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_PRESSED       = 2'd2;
  localparam logic [1:0] ST_JUST_RELEASED = 2'd3;

  typedef enum logic [1:0] {
    OP_BUTTON,
    OP_AXIS,
    OP_LINK,
    OP_NOP
  } op_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    op_t          op;
    logic         idx_ok;
    logic [7:0]   index;
    logic         level_down;
    logic [15:0]  raw_axis;
    logic         link_state;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  function automatic logic [1:0] next_status(input logic [1:0] prev, input logic down);
    logic [1:0] res;
    if (down) begin
      res = (prev == ST_RELEASED || prev == ST_JUST_RELEASED) ? ST_JUST_PRESSED : ST_PRESSED;
    end else begin
      res = (prev == ST_PRESSED || prev == ST_JUST_PRESSED) ? ST_JUST_RELEASED : ST_RELEASED;
    end
    return res;
  endfunction

endpackage

FILE: rtl/cbead_front.sv
// Front stage: accept input beats, classify them and hand them to the queue.
`timescale 1ns / 1ps

module cbead_front
  import cbead_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_index,
  input  logic        in_level_down,
  input  logic signed [15:0] in_raw_axis,
  input  logic        in_link_state,
  input  qstat_t      q_stat,
  output logic        q_push,
  output item_t       q_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign q_push  = valid_r && !q_stat.full;
  assign in_full = valid_r && q_stat.full;
  assign accept  = in_push && !in_full;
  assign q_item  = item_r;

  always_comb begin
    item_nxt            = item_r;
    item_nxt.index      = in_index;
    item_nxt.level_down = in_level_down;
    item_nxt.raw_axis   = in_raw_axis;
    item_nxt.link_state = in_link_state;
    case (in_mode)
      MODE_BUTTON: begin
        item_nxt.op     = OP_BUTTON;
        item_nxt.idx_ok = ({1'b0, in_index} < 9'(NUM_BUTTONS));
      end
      MODE_AXIS: begin
        item_nxt.op     = OP_AXIS;
        item_nxt.idx_ok = ({1'b0, in_index} < 9'(NUM_AXES));
      end
      MODE_LINK: begin
        item_nxt.op     = OP_LINK;
        item_nxt.idx_ok = 1'b1;
      end
      default: begin
        item_nxt.op     = OP_NOP;
        item_nxt.idx_ok = 1'b0;
      end
    endcase
    valid_nxt = accept ? 1'b1 : (q_push ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/cbead_fifo.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module cbead_fifo
  import cbead_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_item,
  input  logic   pop,
  output item_t  head,
  output qstat_t stat
);

  item_t          slot_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QPW+1)'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(wr_r + 1'b1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : QPW'(rd_r + 1'b1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = (QPW+1)'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = (QPW+1)'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/cbead_div.sv
// Restoring divider, one quotient bit per cycle, for the deadzone rescale.
`timescale 1ns / 1ps

module cbead_div
  import cbead_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [15:0] quotient
);

  // Computes floor((dividend << 15) / divisor); the quotient never exceeds 2^15.
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] low_r, low_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic        fits;

  assign done     = done_r;
  assign quotient = quo_r;
  assign trial    = {rem_r, low_r[15]};
  assign fits     = (trial >= {1'b0, req.divisor});

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (req.start) begin
      rem_nxt  = {1'b0, req.dividend[15:1]};
      low_nxt  = {req.dividend[0], 15'd0};
      quo_nxt  = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(trial - {1'b0, req.divisor}) : trial[15:0];
      low_nxt = {low_r[14:0], 1'b0};
      quo_nxt = {quo_r[14:0], fits};
      cnt_nxt = 5'(cnt_r - 1'b1);
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

endmodule

FILE: rtl/cbead_back.sv
// Back stage: update button, axis and link state and present one result beat per item.
`timescale 1ns / 1ps

module cbead_back
  import cbead_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [14:0] cfg_deadzone,
  input  qstat_t      q_stat,
  input  item_t       q_head,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_press_status,
  output logic signed [15:0] out_axis_out,
  output logic        out_index_ok,
  output logic        out_is_connected
);

  back_state_t state_r, state_nxt;

  logic [1:0]  btn_r [NUM_BUTTONS];
  logic [15:0] axs_r [NUM_AXES];
  logic        link_r, link_nxt;
  logic [14:0] dz_r;

  logic             pend_neg_r, pend_neg_nxt;
  logic [AXS_IW-1:0] pend_idx_r, pend_idx_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [15:0] oa_r, oa_nxt;
  logic        ok_r, ok_nxt;
  logic        oc_r, oc_nxt;

  logic        produce, out_free;
  logic        btn_we, axs_we, clear_all;
  logic [1:0]  btn_wd;
  logic [15:0] axs_wd;
  logic [AXS_IW-1:0] axs_wa;
  logic [BTN_IW-1:0] btn_a;
  logic [16:0] mag;
  logic        neg;
  div_req_t    dreq;
  logic        div_done;
  logic [15:0] div_q;
  logic [14:0] clamped;

  cbead_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free         = !ov_r || out_pop;
  assign out_empty        = !ov_r;
  assign out_press_status = os_r;
  assign out_axis_out     = oa_r;
  assign out_index_ok     = ok_r;
  assign out_is_connected = oc_r;

  assign btn_a   = q_head.index[BTN_IW-1:0];
  assign neg     = q_head.raw_axis[15];
  assign mag     = neg ? 17'(17'h10000 - {1'b0, q_head.raw_axis})
                       : {1'b0, q_head.raw_axis};
  assign clamped = div_q[15] ? 15'h7fff : div_q[14:0];

  always_comb begin
    state_nxt    = state_r;
    link_nxt     = link_r;
    pend_neg_nxt = pend_neg_r;
    pend_idx_nxt = pend_idx_r;
    q_pop        = 1'b0;
    produce      = 1'b0;
    btn_we       = 1'b0;
    btn_wd       = ST_RELEASED;
    axs_we       = 1'b0;
    axs_wa       = pend_idx_r;
    axs_wd       = '0;
    clear_all    = 1'b0;
    os_nxt       = ST_RELEASED;
    oa_nxt       = '0;
    ok_nxt       = 1'b0;
    oc_nxt       = link_r;
    dreq.start    = 1'b0;
    dreq.dividend = 16'(mag - {2'b0, dz_r});
    dreq.divisor  = 16'(17'h8000 - {2'b0, dz_r});
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && out_free) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_BUTTON: begin
              produce = 1'b1;
              if (q_head.idx_ok) begin
                btn_we = 1'b1;
                btn_wd = next_status(btn_r[btn_a], q_head.level_down);
                os_nxt = btn_wd;
                ok_nxt = 1'b1;
              end
            end
            OP_AXIS: begin
              if (!q_head.idx_ok) begin
                produce = 1'b1;
              end else if (mag < {2'b0, dz_r}) begin
                // inside the deadzone: store zero right away
                produce = 1'b1;
                axs_we  = 1'b1;
                axs_wa  = q_head.index[AXS_IW-1:0];
                ok_nxt  = 1'b1;
              end else begin
                dreq.start   = 1'b1;
                pend_neg_nxt = neg;
                pend_idx_nxt = q_head.index[AXS_IW-1:0];
                state_nxt    = BK_DIV;
              end
            end
            OP_LINK: begin
              produce  = 1'b1;
              ok_nxt   = 1'b1;
              link_nxt = q_head.link_state;
              oc_nxt   = q_head.link_state;
              clear_all = link_r && !q_head.link_state;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        if (div_done && out_free) begin
          produce   = 1'b1;
          axs_we    = 1'b1;
          axs_wd    = pend_neg_r ? 16'(17'h10000 - {2'b0, clamped}) : {1'b0, clamped};
          oa_nxt    = axs_wd;
          ok_nxt    = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    ov_nxt = produce ? 1'b1 : (out_pop ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      link_r  <= 1'b0;
      dz_r    <= DEADZONE_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      link_r  <= link_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        dz_r <= cfg_deadzone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        btn_r[i] <= ST_RELEASED;
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        axs_r[i] <= '0;
      end
    end else begin
      if (btn_we) begin
        btn_r[btn_a] <= btn_wd;
      end
      if (axs_we) begin
        axs_r[axs_wa] <= axs_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_neg_r <= pend_neg_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (produce) begin
      os_r <= os_nxt;
      oa_r <= oa_nxt;
      ok_r <= ok_nxt;
      oc_r <= oc_nxt;
    end
  end

endmodule

FILE: rtl/controller_button_edge_and_axis_deadzone_unit.sv
// Top level of the controller button edge tracker and axis deadzone conditioner.
`timescale 1ns / 1ps

// Usage:
//   Input channel: drive in_push with one event beat (in_mode, in_index,
//   in_level_down, in_raw_axis, in_link_state); the beat is taken at a clock
//   edge where in_push is high and in_full is low.
//   Result channel: while out_empty is low the oldest result beat sits on the
//   out_ ports; raise out_pop to take it. Exactly one result per event.
//   Configuration: cfg_we writes cfg_deadzone (Q0.15) at the clock edge;
//   write it only while no event is in flight.
// Flow:
//   Button, link, invalid and in-deadzone axis events pass through the queue
//   push and the back update register before they appear. Axis samples on or past
//   the deadzone edge go through the restoring divider in the back stage, which
//   takes no new event until the division is done; other events go at one per
//   cycle while out_pop is held high.
// Reset (rst_n low, synchronous): all buttons released, all axes zero, link
//   down, deadzone back to 6554, queues empty.
// Stall: when out_pop stays low the single result register holds; the back
//   stops, the queue fills and then in_full rises. No beat is lost.

module controller_button_edge_and_axis_deadzone_unit
  import cbead_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_index,
  input  logic        in_level_down,
  input  logic signed [15:0] in_raw_axis,
  input  logic        in_link_state,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_press_status,
  output logic signed [15:0] out_axis_out,
  output logic        out_index_ok,
  output logic        out_is_connected,
  input  logic        cfg_we,
  input  logic [14:0] cfg_deadzone
);

  qstat_t q_stat;
  item_t  push_item, head_item;
  logic   q_push, q_pop;

  // accept and classify
  cbead_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_index      (in_index),
    .in_level_down (in_level_down),
    .in_raw_axis   (in_raw_axis),
    .in_link_state (in_link_state),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // decouple the two sides
  cbead_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (head_item),
    .stat      (q_stat)
  );

  // execute against the state tables and hold the result beat
  cbead_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_deadzone     (cfg_deadzone),
    .q_stat           (q_stat),
    .q_head           (head_item),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_press_status (out_press_status),
    .out_axis_out     (out_axis_out),
    .out_index_ok     (out_index_ok),
    .out_is_connected (out_is_connected)
  );

endmodule
